/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/pidaw_pkg.sv */
// ----------------------------------------------------------------------------
// pidaw_pkg
// types, register indexes and fixed-point helpers for the pid controller
// ----------------------------------------------------------------------------
package pidaw_pkg;

   // register indexes
   localparam logic [2:0] REG_GAIN_P          = 3'd0;
   localparam logic [2:0] REG_GAIN_I          = 3'd1;
   localparam logic [2:0] REG_GAIN_D          = 3'd2;
   localparam logic [2:0] REG_LOOP_PERIOD     = 3'd3;
   localparam logic [2:0] REG_INV_LOOP_PERIOD = 3'd4;
   localparam logic [2:0] REG_INTEGRAL_LIMIT  = 3'd5;

   localparam int QSHIFT = 16;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_DIF,
      ST_INT,
      ST_DER,
      ST_PTERM,
      ST_ITERM,
      ST_DTERM
   } state_type;

   // shared multiplier operand pairs
   typedef enum logic [2:0] {
      MUL_ERR_PERIOD,
      MUL_DIF_INV,
      MUL_GP_ERR,
      MUL_GI_INT,
      MUL_GD_DER
   } mul_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load_in;
      logic        ld_err;
      logic        ld_dif;
      logic        ld_int;
      logic        ld_der;
      logic        acc_init;
      logic        acc_add;
      logic        ld_out;
      logic        mul_en;
      mul_sel_type mul_sel;
   } cmd_type;

   // q16.16 product: floor shift, then saturate to 32 bits
   function automatic logic signed [31:0] q_sat(input logic signed [63:0] p);
      logic signed [47:0] sh;
      sh = 48'(p >>> QSHIFT);
      if (sh[47:31] == {17{1'b0}} || sh[47:31] == {17{1'b1}}) begin
         q_sat = sh[31:0];
      end else if (sh[47]) begin
         q_sat = 32'sh8000_0000;
      end else begin
         q_sat = 32'sh7fff_ffff;
      end
   endfunction

   // saturate a 33-bit sum
   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      if (v[32] == v[31]) begin
         sat33 = v[31:0];
      end else if (v[32]) begin
         sat33 = 32'sh8000_0000;
      end else begin
         sat33 = 32'sh7fff_ffff;
      end
   endfunction

   // saturate a 34-bit sum
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         sat34 = v[31:0];
      end else if (v[33]) begin
         sat34 = 32'sh8000_0000;
      end else begin
         sat34 = 32'sh7fff_ffff;
      end
   endfunction

endpackage

/* design/pidaw_ctrl.sv */
// ----------------------------------------------------------------------------
// pidaw_ctrl
// sequencer for one loop tick and owner of the result valid flag
// ----------------------------------------------------------------------------
module pidaw_ctrl
   import pidaw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;

   assign slot_free = !out_valid_ff || out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (in_valid) state_in = ST_ERR;
         ST_ERR:   state_in = ST_DIF;
         ST_DIF:   state_in = ST_INT;
         ST_INT:   state_in = ST_DER;
         ST_DER:   state_in = ST_PTERM;
         ST_PTERM: state_in = ST_ITERM;
         ST_ITERM: state_in = ST_DTERM;
         ST_DTERM: if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_ERR_PERIOD;
      in_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.load_in = in_valid;
         end
         ST_ERR: cmd.ld_err = 1'b1;
         ST_DIF: begin
            cmd.ld_dif  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR_PERIOD;
         end
         ST_INT: begin
            cmd.ld_int  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DIF_INV;
         end
         ST_DER: begin
            cmd.ld_der  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GP_ERR;
         end
         ST_PTERM: begin
            cmd.acc_init = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_GI_INT;
         end
         ST_ITERM: begin
            cmd.acc_add = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GD_DER;
         end
         ST_DTERM: cmd.ld_out = slot_free;
         default: ;
      endcase
   end

   // result valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.ld_out) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

endmodule

/* design/pidaw_dp.sv */
// ----------------------------------------------------------------------------
// pidaw_dp
// registers, loop state and shared 32x32 multiplier of the pid controller
// ----------------------------------------------------------------------------
module pidaw_dp
   import pidaw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic signed [31:0] setpoint,
   input  logic signed [31:0] measured,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic signed [31:0] drive
);

   // configuration registers
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [30:0]        period_ff, inv_period_ff, limit_ff;

   // loop state and working registers
   logic signed [31:0] setpoint_ff, measured_ff;
   logic signed [31:0] err_ff, dif_ff, integ_ff, deriv_ff, last_err_ff;
   logic signed [31:0] drive_ff, drive_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [33:0] acc_ff, acc_in;
   logic signed [31:0] mul_a, mul_b, qprod;
   logic signed [31:0] err_in, dif_in, integ_in, isum;
   logic signed [32:0] lim_pos, lim_neg, isum_x;
   logic signed [33:0] total;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         period_ff     <= 31'd65536;
         inv_period_ff <= 31'd65536;
         limit_ff      <= 31'h7fff_ffff;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_P:          gain_p_ff     <= csr_wdata;
            REG_GAIN_I:          gain_i_ff     <= csr_wdata;
            REG_GAIN_D:          gain_d_ff     <= csr_wdata;
            REG_LOOP_PERIOD:     period_ff     <= csr_wdata[30:0];
            REG_INV_LOOP_PERIOD: inv_period_ff <= csr_wdata[30:0];
            REG_INTEGRAL_LIMIT:  limit_ff      <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_ERR_PERIOD: begin
            mul_a = err_ff;
            mul_b = {1'b0, period_ff};
         end
         MUL_DIF_INV: begin
            mul_a = dif_ff;
            mul_b = {1'b0, inv_period_ff};
         end
         MUL_GP_ERR: begin
            mul_a = gain_p_ff;
            mul_b = err_ff;
         end
         MUL_GI_INT: begin
            mul_a = gain_i_ff;
            mul_b = integ_ff;
         end
         MUL_GD_DER: begin
            mul_a = gain_d_ff;
            mul_b = deriv_ff;
         end
         default: begin
            mul_a = err_ff;
            mul_b = err_ff;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign qprod   = q_sat(prod_ff);

   // error and error difference
   assign err_in = sat33(33'(setpoint_ff) - 33'(measured_ff));
   assign dif_in = sat33(33'(err_ff) - 33'(last_err_ff));

   // integral update with clamp to plus or minus the limit
   assign isum    = sat33(33'(integ_ff) + 33'(qprod));
   assign isum_x  = 33'(isum);
   assign lim_pos = $signed({2'b00, limit_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (isum_x > lim_pos) begin
         integ_in = lim_pos[31:0];
      end else if (isum_x < lim_neg) begin
         integ_in = lim_neg[31:0];
      end else begin
         integ_in = isum;
      end
   end

   // term accumulation and final saturation
   assign total    = acc_ff + 34'(qprod);
   assign drive_in = sat34(total);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_init) begin
         acc_in = 34'(qprod);
      end else if (cmd.acc_add) begin
         acc_in = total;
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         if (cmd.ld_int) integ_ff    <= integ_in;
         if (cmd.ld_dif) last_err_ff <= err_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         setpoint_ff <= setpoint;
         measured_ff <= measured;
      end
      if (cmd.ld_err) err_ff   <= err_in;
      if (cmd.ld_dif) dif_ff   <= dif_in;
      if (cmd.ld_der) deriv_ff <= qprod;
      if (cmd.mul_en) prod_ff  <= prod_in;
      acc_ff <= acc_in;
      if (cmd.ld_out) drive_ff <= drive_in;
   end

   assign drive = drive_ff;

endmodule

/* design/pid_controller_antiwindup.sv */
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// q16.16 pid controller with integral clamp and one shared multiplier
// ----------------------------------------------------------------------------
//  channel | ports   | payload (low bit up)
//  input   | req_*   | tdata: setpoint[31:0], measured[63:32]
//  result  | rsp_*   | tdata: drive[31:0]
//  config  | csr_*   | index 0..5, data 32 bits, write only
//
//  a tick runs capture, error, then five passes through the
//  single registered 32x32 multiplier with its saturating adders.
//  a new tick is taken only when the sequencer is idle.
//  the result register lets the next tick start while a result waits;
//  the last step stalls until that register is free.
//  reset is synchronous and clears gains, integral and last error.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
   import pidaw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // setpoint, measured
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type            cmd;
   logic signed [31:0] drive;

   pidaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd)
   );

   pidaw_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .setpoint  (req_tdata[31:0]),
      .measured  (req_tdata[63:32]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .drive     (drive)
   );

   assign rsp_tdata = drive;

endmodule

/* design/pidaw_checker.sv */
// ----------------------------------------------------------------------------
// pidaw_checker
// port-level checks of the pid controller, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidaw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // one tick at a time: no second transfer right after an input transfer
   `ASSERT_NEXT(a_one_tick, req_tvalid && req_tready, !req_tready, "input taken while busy")

   // a result does not rise right after its input transfer
   `ASSERT_NEXT(a_no_early, req_tvalid && req_tready, !$rose(rsp_tvalid), "result too early")

   // a fresh result leaves the sequencer idle
   `ASSERT_NOW(a_idle_after, $rose(rsp_tvalid), req_tready, "not idle after result")

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/pid_controller_antiwindup_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_test
// self-checking bench for the q16.16 pid controller with integral clamp
// ----------------------------------------------------------------------------
//  every accepted tick goes through a bit-exact model of the controller
//  (saturating sums, floor-shifted products, integral clamp, last error),
//  and each drive transfer is compared with the oldest predicted value.
//  gains, periods and the integral limit change between phases, only once
//  the controller has gone quiet. both stream sides idle at random.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_test
   import pidaw_pkg::*;
();

   localparam logic [31:0] Q_ONE      = 32'h0001_0000;
   localparam logic [31:0] S32_MAXV   = 32'h7fff_ffff;
   localparam logic [31:0] S32_MINV   = 32'h8000_0000;
   localparam logic [2:0]  REG_SPARE6 = 3'd6;
   localparam logic [2:0]  REG_SPARE7 = 3'd7;
   localparam int          RAND_PHASES     = 15;
   localparam int          TICKS_PER_PHASE = 110;
   localparam int          SETTLE_CYCLES   = 24;
   localparam int unsigned CYCLE_LIMIT     = 600000;

   // ------------------------------------------------------------------------
   // controller model and pending drive values
   // ------------------------------------------------------------------------
   class drive_board;
      localparam longint S32_TOP = 64'sd2147483647;
      localparam longint S32_BOT = -64'sd2147483648;

      logic signed [31:0] kp, ki, kd;
      logic [30:0]        period, inv_period, clamp_limit;
      logic signed [31:0] integ_acc, prev_err;
      logic [31:0]        drive_q[$];
      int                 errors, ticks, checked;

      function new();
         kp = 0;
         ki = 0;
         kd = 0;
         period      = 31'(Q_ONE);
         inv_period  = 31'(Q_ONE);
         clamp_limit = 31'h7fff_ffff;
         integ_acc   = 0;
         prev_err    = 0;
         errors  = 0;
         ticks   = 0;
         checked = 0;
      endfunction

      function logic signed [31:0] sat_wide(input longint v);
         if (v > S32_TOP) return S32_MAXV;
         if (v < S32_BOT) return S32_MINV;
         return v[31:0];
      endfunction

      // q16.16 product, floor shift, saturate
      function logic signed [31:0] qprod(input logic signed [31:0] a, input longint b);
         longint p;
         p = longint'(a) * b;
         return sat_wide(p >>> 16);
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [31:0] val);
         case (idx)
            REG_GAIN_P:          kp = val;
            REG_GAIN_I:          ki = val;
            REG_GAIN_D:          kd = val;
            REG_LOOP_PERIOD:     period = val[30:0];
            REG_INV_LOOP_PERIOD: inv_period = val[30:0];
            REG_INTEGRAL_LIMIT:  clamp_limit = val[30:0];
            default: ;
         endcase
      endfunction

      // one accepted tick: advance the loop state and queue its drive
      function void note_tick(input logic signed [31:0] sp, input logic signed [31:0] ms);
         logic signed [31:0] err, integ, dif, deriv;
         longint             acc, lim, total;
         err = sat_wide(longint'(sp) - longint'(ms));
         acc = longint'(sat_wide(longint'(integ_acc)
                                 + longint'(qprod(err, longint'({1'b0, period})))));
         lim = longint'({1'b0, clamp_limit});
         if (acc > lim) acc = lim;
         if (acc < -lim) acc = -lim;
         integ = acc[31:0];
         dif   = sat_wide(longint'(err) - longint'(prev_err));
         deriv = qprod(dif, longint'({1'b0, inv_period}));
         total = longint'(qprod(kp, longint'(err)))
               + longint'(qprod(ki, longint'(integ)))
               + longint'(qprod(kd, longint'(deriv)));
         integ_acc = integ;
         prev_err  = err;
         drive_q.push_back(sat_wide(total));
         ticks++;
      endfunction

      function void check_drive(input logic [31:0] got);
         logic [31:0] want;
         if (drive_q.size() == 0) begin
            $error("drive: no tick pending, got %h", got);
            errors++;
            return;
         end
         want = drive_q.pop_front();
         checked++;
         if (got !== want) begin
            $error("drive: expected %h, actual %h", want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   drive_board  board = new();
   bit          gaps_on = 1'b1;
   int unsigned cycle_count = 0;
   int          settings = 0;

   pid_controller_antiwindup u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d drive values pending",
                  cycle_count, board.drive_q.size());
         $display("pid_controller_antiwindup test failed");
         $finish;
      end
   end

   // result side: random back-pressure and checking of each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_drive(rsp_tdata);
         rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 17);
      end
   end

   // register write, with the write enable dropped again before the task returns
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] gp, input logic [31:0] gi,
                            input logic [31:0] gd, input logic [31:0] per,
                            input logic [31:0] inv, input logic [31:0] lim);
      write_reg(REG_GAIN_P, gp);
      write_reg(REG_GAIN_I, gi);
      write_reg(REG_GAIN_D, gd);
      write_reg(REG_LOOP_PERIOD, per);
      write_reg(REG_INV_LOOP_PERIOD, inv);
      write_reg(REG_INTEGRAL_LIMIT, lim);
      settings++;
   endtask

   // input side: optional gap, then hold the tick until transfer
   task automatic send_tick(input logic [31:0] sp, input logic [31:0] ms);
      while (gaps_on && $urandom_range(0, 99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ms, sp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_tick(sp, ms);
   endtask

   // let every pending drive come back, then let the sequencer settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return $urandom_range(0, 1) ? S32_MAXV : S32_MINV;
         2: return $urandom();
         default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      endcase
   endfunction

   // 31-bit fields; bit 31 random since the block drops it
   function automatic logic [31:0] pick_period();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'd0;
         1: v = 32'd1;
         2: v = S32_MAXV;
         3: v = $urandom();
         default: v = $urandom_range(1, 1 << 18);
      endcase
      v[31] = $urandom_range(0, 1);
      return v;
   endfunction

   function automatic logic [31:0] pick_limit();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = 32'd0;
         1: v = S32_MAXV;
         2: v = $urandom();
         default: v = $urandom_range(0, 1 << 24);
      endcase
      v[31] = $urandom_range(0, 1);
      return v;
   endfunction

   function automatic logic [31:0] pick_value(input int mode);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? S32_MAXV : S32_MINV;
         1, 2, 3: return $urandom();
         default:
            if (mode == 2) return $urandom();
            else return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      endcase
   endfunction

   // stimulus
   initial begin
      int          mode;
      int          target, plant;
      logic [31:0] sp, ms;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_GAIN_P;
      csr_wdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset gains are zero: drive stays zero even at full error
      send_tick(S32_MAXV, S32_MINV);
      drain();

      // unit gains, field extremes and sign flips
      write_all(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, S32_MAXV);
      send_tick(32'd0, 32'd0);
      send_tick(S32_MAXV, S32_MINV);
      send_tick(S32_MINV, S32_MAXV);
      send_tick(S32_MAXV, S32_MAXV);
      send_tick(S32_MINV, S32_MINV);
      send_tick(Q_ONE, 32'd0);
      send_tick(32'd0, Q_ONE);
      send_tick(32'hffff_ffff, 32'd0);
      send_tick(32'd1, 32'd0);
      drain();

      // zero period, zero reciprocal, zero limit; spare indexes are ignored
      write_all(Q_ONE, Q_ONE, Q_ONE, 32'd0, 32'h8000_0000, 32'd0);
      write_reg(REG_SPARE6, 32'hdead_beef);
      write_reg(REG_SPARE7, 32'hffff_ffff);
      send_tick(32'h0005_0000, Q_ONE);
      send_tick(32'h0005_0000, Q_ONE);
      send_tick(S32_MINV, S32_MAXV);
      drain();

      // extreme gains and periods, tight clamp
      write_all(S32_MINV, S32_MAXV, S32_MINV, 32'hffff_ffff, S32_MAXV, Q_ONE);
      send_tick(S32_MAXV, S32_MINV);
      send_tick(32'd1, 32'd0);
      send_tick(S32_MINV, S32_MAXV);
      send_tick(32'd0, 32'd0);
      drain();

      // random phases: loop-like tracking, small values, or wide values
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         gaps_on = !(ph == 6 || ph == 7);
         write_all(pick_gain(), pick_gain(), pick_gain(),
                   pick_period(), pick_period(), pick_limit());
         if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE6 + 3'($urandom_range(0, 1)),
                                                  $urandom());
         mode   = $urandom_range(0, 3) == 0 ? 2 : ($urandom_range(0, 2) == 0 ? 1 : 0);
         target = $urandom_range(0, 1 << 22) - (1 << 21);
         plant  = $urandom_range(0, 1 << 22) - (1 << 21);
         for (int k = 0; k < TICKS_PER_PHASE; k++) begin
            if (mode == 0 && $urandom_range(0, 9) != 0) begin
               // plant creeps toward a setpoint that steps now and then
               if ($urandom_range(0, 19) == 0)
                  target = $urandom_range(0, 1 << 22) - (1 << 21);
               plant = plant + ((target - plant) >>> 3)
                             + int'($urandom_range(0, 511)) - 256;
               sp = target;
               ms = plant;
            end else begin
               sp = pick_value(mode);
               ms = pick_value(mode);
            end
            send_tick(sp, ms);
         end
         drain();
      end

      $display("ran %0d ticks under %0d register settings, %0d drive transfers checked",
               board.ticks, settings, board.checked);
      $display("settings spanned zero and extreme gains, periods and integral limits");
      if (board.errors == 0 && board.drive_q.size() == 0) begin
         $display("pid_controller_antiwindup test passed");
      end else begin
         $display("pid_controller_antiwindup test failed");
      end
      $finish;
   end

endmodule
